FILE: rtl/tpu_pkg.sv
// ----------------------------------------------------------------------------
// tpu_pkg
// Shared types, codes and helpers of the telemetry TLV parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpu_pkg;

  localparam int unsigned TEXT_CAP_DEF = 32;
  localparam int unsigned NUM_TEXTS    = 4;
  localparam int unsigned STAGE_BYTES  = 4;

  // input kinds
  localparam logic [2:0] KIND_BYTE       = 3'd0;
  localparam logic [2:0] KIND_READ       = 3'd1;
  localparam logic [2:0] KIND_CLEAR      = 3'd2;
  localparam logic [2:0] KIND_CONNECT    = 3'd3;
  localparam logic [2:0] KIND_DISCONNECT = 3'd4;

  // record types
  localparam logic [7:0] TYPE_STATE    = 8'h01;
  localparam logic [7:0] TYPE_AGENT    = 8'h02;
  localparam logic [7:0] TYPE_MESSAGE  = 8'h05;
  localparam logic [7:0] TYPE_PROGRESS = 8'h06;
  localparam logic [7:0] TYPE_TIME     = 8'h07;
  localparam logic [7:0] TYPE_LIGHT    = 8'h08;

  localparam logic [7:0] LEVEL_RST      = 8'd100;
  localparam logic [7:0] IDLE_CODE_RST  = 8'd1;
  localparam logic [7:0] DISC_CODE_RST  = 8'd0;

  // configuration register indexes
  localparam logic CFG_IDLE_STATE = 1'b0;
  localparam logic CFG_DISC_STATE = 1'b1;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_VALUE
  } phase_e;

  typedef enum logic [2:0] {
    OP_BYTE,
    OP_READ,
    OP_CLEAR,
    OP_CONNECT,
    OP_DISCONNECT
  } op_e;

  typedef enum logic [2:0] {
    CM_NONE,
    CM_STATE,
    CM_TEXT,
    CM_PROGRESS,
    CM_TIME,
    CM_LIGHT,
    CM_UNKNOWN
  } commit_e;

  // one queued command from the parser front to the executing back
  typedef struct packed {
    op_e         op;
    logic        pkt_start;
    logic        mal_set;
    commit_e     commit;
    logic        text_wr;
    logic [1:0]  text_sel;
    logic [7:0]  text_addr;
    logic [7:0]  wr_byte;
    logic [31:0] value;     // staged bytes, first byte in the top lane
    logic [7:0]  text_len;
    logic [4:0]  rd_index;
  } cmd_t;

  // characters of the default text "None"
  function automatic logic [7:0] none_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0:    c = 8'h4E;
      2'd1:    c = 8'h6F;
      2'd2:    c = 8'h6E;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? 8'hFF : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tlv_telemetry_parser_unit.sv
// ----------------------------------------------------------------------------
// tlv_telemetry_parser_unit
// TLV telemetry parser: byte-stream records update a telemetry store that
// is returned as a snapshot on read requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per transaction:
//   a packet byte, a read, a clear of the updated flag, or a link connect or
//   disconnect. Only reads produce a result on the output channel
//   (out_valid_o / out_stall_i). The config port (cfg_valid_i / cfg_ready_o)
//   writes the idle and disconnected state codes; it is always ready and
//   should only be written while no transaction is in flight.
//   Throughput is one item per cycle while the queue is not full. The front
//   parser classifies a byte in the cycle it is taken; the back end applies
//   it from a two-entry queue, so a read passes through a queue entry and
//   then the registered result slot. Texts live in a single-port-read RAM
//   with registered read data, read as the read leaves the queue.
//   While the receiver stalls, the result holds and the queue keeps taking
//   items; a queued read waits at the head, and the input stalls once the
//   queue fills. Reset returns the parser to a record boundary, the texts to
//   "None" and the store to its defaults, with no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlv_telemetry_parser_unit #(
  parameter int unsigned TEXT_CAP = tpu_pkg::TEXT_CAP_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [1:0]  text_select_i,
  input  wire logic [4:0]  text_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       monitor_state_o,
  output logic [7:0]       progress_done_o,
  output logic [7:0]       progress_max_o,
  output logic [31:0]      sync_seconds_o,
  output logic [7:0]       brightness_o,
  output logic [7:0]       volume_o,
  output logic             updated_flag_o,
  output logic [7:0]       text_char_o,
  output logic [4:0]       text_length_o,
  output logic             malformed_o,
  output logic [7:0]       unknown_count_o,
  output logic [7:0]       applied_count_o
);

  logic          accept;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  tpu_pkg::cmd_t push_cmd;
  tpu_pkg::cmd_t head_cmd;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !q_full;

  tpu_front #(
    .TEXT_CAP (TEXT_CAP)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .text_select_i (text_select_i),
    .text_index_i  (text_index_i),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  tpu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  tpu_back #(
    .TEXT_CAP (TEXT_CAP)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .empty_i          (q_empty),
    .head_i           (head_cmd),
    .pop_o            (pop),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .monitor_state_o  (monitor_state_o),
    .progress_done_o  (progress_done_o),
    .progress_max_o   (progress_max_o),
    .sync_seconds_o   (sync_seconds_o),
    .brightness_o     (brightness_o),
    .volume_o         (volume_o),
    .updated_flag_o   (updated_flag_o),
    .text_char_o      (text_char_o),
    .text_length_o    (text_length_o),
    .malformed_o      (malformed_o),
    .unknown_count_o  (unknown_count_o),
    .applied_count_o  (applied_count_o)
  );

endmodule

`default_nettype wire

FILE: rtl/tpu_ram.sv
// ----------------------------------------------------------------------------
// tpu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/tpu_front.sv
// ----------------------------------------------------------------------------
// tpu_front
// Byte-level TLV parser: tracks record phase, stages value bytes and turns
// each accepted item of a known kind into one command for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpu_front #(
  parameter int unsigned TEXT_CAP = tpu_pkg::TEXT_CAP_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [2:0]   kind_i,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         last_byte_i,
  input  wire logic [1:0]   text_select_i,
  input  wire logic [4:0]   text_index_i,
  output logic              push_o,
  output tpu_pkg::cmd_t     cmd_o
);

  localparam logic [7:0] TxtMax = 8'(TEXT_CAP - 1);

  tpu_pkg::phase_e phase_q, phase_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      vc_q, vc_d;
  logic            open_q, open_d;
  logic [7:0]      stage_q [tpu_pkg::STAGE_BYTES];
  logic [7:0]      stage_d [tpu_pkg::STAGE_BYTES];

  logic            is_text;
  logic            fin;
  logic [7:0]      fin_len;
  tpu_pkg::cmd_t   cmd;

  assign is_text = (type_q >= tpu_pkg::TYPE_AGENT) && (type_q <= tpu_pkg::TYPE_MESSAGE);

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    len_d   = len_q;
    vc_d    = vc_q;
    open_d  = open_q;
    stage_d = stage_q;
    fin     = 1'b0;
    fin_len = len_q;
    push_o  = 1'b0;

    cmd           = '0;
    cmd.op        = tpu_pkg::OP_BYTE;
    cmd.commit    = tpu_pkg::CM_NONE;
    cmd.wr_byte   = data_byte_i;
    cmd.text_addr = vc_q;
    cmd.rd_index  = text_index_i;

    unique case (kind_i)
      tpu_pkg::KIND_BYTE: begin
        push_o        = accept_i;
        cmd.pkt_start = !open_q;
        cmd.text_sel  = 2'(type_q - tpu_pkg::TYPE_AGENT);
        unique case (phase_q)
          tpu_pkg::PH_LEN: begin
            len_d   = data_byte_i;
            vc_d    = '0;
            fin_len = data_byte_i;
            if (data_byte_i == 8'd0) begin
              fin     = 1'b1;
              phase_d = tpu_pkg::PH_TYPE;
            end else begin
              phase_d = tpu_pkg::PH_VALUE;
            end
          end
          tpu_pkg::PH_VALUE: begin
            if (vc_q < 8'(tpu_pkg::STAGE_BYTES)) begin
              stage_d[vc_q[1:0]] = data_byte_i;
            end
            cmd.text_wr = is_text && (vc_q < TxtMax);
            vc_d = vc_q + 8'd1;
            if (vc_d == len_q) begin
              fin     = 1'b1;
              phase_d = tpu_pkg::PH_TYPE;
            end
          end
          default: begin
            type_d  = data_byte_i;
            phase_d = tpu_pkg::PH_LEN;
          end
        endcase

        if (fin) begin
          priority if (type_q == tpu_pkg::TYPE_STATE) begin
            cmd.commit = (fin_len >= 8'd1) ? tpu_pkg::CM_STATE : tpu_pkg::CM_NONE;
          end else if (is_text) begin
            cmd.commit = tpu_pkg::CM_TEXT;
          end else if (type_q == tpu_pkg::TYPE_PROGRESS) begin
            cmd.commit = (fin_len >= 8'd2) ? tpu_pkg::CM_PROGRESS : tpu_pkg::CM_NONE;
          end else if (type_q == tpu_pkg::TYPE_TIME) begin
            cmd.commit = (fin_len >= 8'd4) ? tpu_pkg::CM_TIME : tpu_pkg::CM_NONE;
          end else if (type_q == tpu_pkg::TYPE_LIGHT) begin
            cmd.commit = (fin_len >= 8'd2) ? tpu_pkg::CM_LIGHT : tpu_pkg::CM_NONE;
          end else begin
            cmd.commit = tpu_pkg::CM_UNKNOWN;
          end
        end
        cmd.text_len = (fin_len < TxtMax) ? fin_len : TxtMax;
        cmd.value    = {stage_d[0], stage_d[1], stage_d[2], stage_d[3]};

        if (last_byte_i) begin
          cmd.mal_set = (phase_d == tpu_pkg::PH_VALUE);
          phase_d     = tpu_pkg::PH_TYPE;
          vc_d        = '0;
          open_d      = 1'b0;
        end else begin
          open_d = 1'b1;
        end
      end
      tpu_pkg::KIND_READ: begin
        push_o       = accept_i;
        cmd.op       = tpu_pkg::OP_READ;
        cmd.text_sel = text_select_i;
      end
      tpu_pkg::KIND_CLEAR: begin
        push_o = accept_i;
        cmd.op = tpu_pkg::OP_CLEAR;
      end
      tpu_pkg::KIND_CONNECT: begin
        push_o = accept_i;
        cmd.op = tpu_pkg::OP_CONNECT;
      end
      tpu_pkg::KIND_DISCONNECT: begin
        push_o = accept_i;
        cmd.op = tpu_pkg::OP_DISCONNECT;
      end
      default: begin
        // unused kinds are consumed without a command
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tpu_pkg::PH_TYPE;
      type_q  <= '0;
      len_q   <= '0;
      vc_q    <= '0;
      open_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      vc_q    <= vc_d;
      open_q  <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stage_q <= stage_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tpu_fifo.sv
// ----------------------------------------------------------------------------
// tpu_fifo
// Two-entry command queue between parser front and executing back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpu_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tpu_pkg::cmd_t cmd_i,
  input  wire logic          pop_i,
  output tpu_pkg::cmd_t      head_o,
  output logic               empty_o,
  output logic               full_o
);

  tpu_pkg::cmd_t ent_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;
  logic          do_push;
  logic          do_pop;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tpu_back.sv
// ----------------------------------------------------------------------------
// tpu_back
// Executes queued commands against the telemetry store and drives the
// registered result slot. Texts are double banked so a record only shows
// once it commits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpu_back #(
  parameter int unsigned TEXT_CAP = tpu_pkg::TEXT_CAP_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_index_i,
  input  wire logic [7:0]    cfg_data_i,
  input  wire logic          empty_i,
  input  wire tpu_pkg::cmd_t head_i,
  output logic               pop_o,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output logic [7:0]         monitor_state_o,
  output logic [7:0]         progress_done_o,
  output logic [7:0]         progress_max_o,
  output logic [31:0]        sync_seconds_o,
  output logic [7:0]         brightness_o,
  output logic [7:0]         volume_o,
  output logic               updated_flag_o,
  output logic [7:0]         text_char_o,
  output logic [4:0]         text_length_o,
  output logic               malformed_o,
  output logic [7:0]         unknown_count_o,
  output logic [7:0]         applied_count_o
);

  localparam int unsigned AddrW  = $clog2(TEXT_CAP);
  localparam int unsigned IdxW   = (AddrW > 5) ? AddrW : 5;
  localparam int unsigned RamDep = tpu_pkg::NUM_TEXTS * 2 * (1 << AddrW);
  localparam int unsigned DefLen = (TEXT_CAP - 1 < 4) ? TEXT_CAP - 1 : 4;
  localparam int unsigned RamAw  = $clog2(RamDep);

  // config and telemetry
  logic [7:0]  idle_code_q, disc_code_q;
  logic [7:0]  mon_q, mon_d;
  logic [7:0]  pdone_q, pdone_d;
  logic [7:0]  ptotal_q, ptotal_d;
  logic [31:0] sync_q, sync_d;
  logic [7:0]  bright_q, bright_d;
  logic [7:0]  vol_q, vol_d;
  logic        upd_q, upd_d;
  logic        mal_q, mal_d;
  logic [7:0]  unk_q, unk_d;
  logic [7:0]  app_q, app_d;

  // per-text bookkeeping
  logic             bank_q [tpu_pkg::NUM_TEXTS];
  logic             bank_d [tpu_pkg::NUM_TEXTS];
  logic             dflt_q [tpu_pkg::NUM_TEXTS];
  logic             dflt_d [tpu_pkg::NUM_TEXTS];
  logic [AddrW-1:0] tlen_q [tpu_pkg::NUM_TEXTS];
  logic [AddrW-1:0] tlen_d [tpu_pkg::NUM_TEXTS];

  // result slot
  logic        out_valid_q, out_valid_d;
  logic [7:0]  o_mon_q, o_pdone_q, o_ptotal_q, o_bright_q, o_vol_q;
  logic [31:0] o_sync_q;
  logic        o_upd_q, o_mal_q;
  logic [7:0]  o_unk_q, o_app_q;
  logic [4:0]  o_len_q;
  logic        char_ram_q;
  logic [7:0]  char_const_q;

  logic              is_read;
  logic              take_read;
  logic [IdxW-1:0]   idx_w;
  logic [IdxW-1:0]   tl_w;
  logic              hit;
  logic              sel_dflt;
  logic [7:0]        const_char;
  logic              ram_we;
  logic [RamAw-1:0]  ram_waddr;
  logic              ram_re;
  logic [RamAw-1:0]  ram_raddr;
  logic [7:0]        ram_rdata;

  assign is_read   = (head_i.op == tpu_pkg::OP_READ);
  assign pop_o     = !empty_i && (!is_read || !out_valid_q || !out_stall_i);
  assign take_read = pop_o && is_read;

  assign idx_w      = IdxW'(head_i.rd_index);
  assign tl_w       = IdxW'(tlen_q[head_i.text_sel]);
  assign hit        = idx_w < tl_w;
  assign sel_dflt   = dflt_q[head_i.text_sel];
  assign const_char = (hit && sel_dflt) ? tpu_pkg::none_char(head_i.rd_index[1:0]) : 8'd0;

  assign ram_re    = take_read && hit && !sel_dflt;
  assign ram_raddr = RamAw'({head_i.text_sel, bank_q[head_i.text_sel], idx_w[AddrW-1:0]});

  // bytes of a text record go to the bank that is not shown
  assign ram_we    = pop_o && (head_i.op == tpu_pkg::OP_BYTE) && head_i.text_wr;
  assign ram_waddr = RamAw'({head_i.text_sel, ~bank_q[head_i.text_sel],
                             head_i.text_addr[AddrW-1:0]});

  tpu_ram #(
    .WIDTH (8),
    .DEPTH (RamDep)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (head_i.wr_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    mon_d    = mon_q;
    pdone_d  = pdone_q;
    ptotal_d = ptotal_q;
    sync_d   = sync_q;
    bright_d = bright_q;
    vol_d    = vol_q;
    upd_d    = upd_q;
    mal_d    = mal_q;
    unk_d    = unk_q;
    app_d    = app_q;
    bank_d   = bank_q;
    dflt_d   = dflt_q;
    tlen_d   = tlen_q;

    if (pop_o) begin
      unique case (head_i.op)
        tpu_pkg::OP_BYTE: begin
          if (head_i.pkt_start) begin
            mal_d = 1'b0;
            unk_d = '0;
            app_d = '0;
          end
          unique case (head_i.commit)
            tpu_pkg::CM_STATE: begin
              mon_d = head_i.value[31:24];
            end
            tpu_pkg::CM_TEXT: begin
              bank_d[head_i.text_sel] = ~bank_q[head_i.text_sel];
              dflt_d[head_i.text_sel] = 1'b0;
              tlen_d[head_i.text_sel] = head_i.text_len[AddrW-1:0];
            end
            tpu_pkg::CM_PROGRESS: begin
              pdone_d  = head_i.value[31:24];
              ptotal_d = head_i.value[23:16];
            end
            tpu_pkg::CM_TIME: begin
              sync_d = head_i.value;
            end
            tpu_pkg::CM_LIGHT: begin
              bright_d = head_i.value[31:24];
              vol_d    = head_i.value[23:16];
            end
            tpu_pkg::CM_UNKNOWN: begin
              unk_d = tpu_pkg::sat_inc(unk_d);
            end
            default: begin
            end
          endcase
          if (head_i.commit != tpu_pkg::CM_NONE && head_i.commit != tpu_pkg::CM_UNKNOWN) begin
            upd_d = 1'b1;
            app_d = tpu_pkg::sat_inc(app_d);
          end
          if (head_i.mal_set) begin
            mal_d = 1'b1;
          end
        end
        tpu_pkg::OP_CLEAR: begin
          upd_d = 1'b0;
        end
        tpu_pkg::OP_CONNECT: begin
          mon_d = idle_code_q;
          upd_d = 1'b1;
        end
        tpu_pkg::OP_DISCONNECT: begin
          mon_d = disc_code_q;
          upd_d = 1'b1;
        end
        default: begin
          // reads leave the store as it is
        end
      endcase
    end

    if (take_read) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_code_q <= tpu_pkg::IDLE_CODE_RST;
      disc_code_q <= tpu_pkg::DISC_CODE_RST;
      mon_q       <= tpu_pkg::DISC_CODE_RST;
      pdone_q     <= '0;
      ptotal_q    <= '0;
      sync_q      <= '0;
      bright_q    <= tpu_pkg::LEVEL_RST;
      vol_q       <= tpu_pkg::LEVEL_RST;
      upd_q       <= 1'b0;
      mal_q       <= 1'b0;
      unk_q       <= '0;
      app_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < tpu_pkg::NUM_TEXTS; i++) begin
        bank_q[i] <= 1'b0;
        dflt_q[i] <= 1'b1;
        tlen_q[i] <= AddrW'(DefLen);
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tpu_pkg::CFG_IDLE_STATE: idle_code_q <= cfg_data_i;
          default:                 disc_code_q <= cfg_data_i;
        endcase
      end
      mon_q       <= mon_d;
      pdone_q     <= pdone_d;
      ptotal_q    <= ptotal_d;
      sync_q      <= sync_d;
      bright_q    <= bright_d;
      vol_q       <= vol_d;
      upd_q       <= upd_d;
      mal_q       <= mal_d;
      unk_q       <= unk_d;
      app_q       <= app_d;
      bank_q      <= bank_d;
      dflt_q      <= dflt_d;
      tlen_q      <= tlen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // snapshot taken when the read leaves the queue
  always_ff @(posedge clk_i) begin
    if (take_read) begin
      o_mon_q      <= mon_q;
      o_pdone_q    <= pdone_q;
      o_ptotal_q   <= ptotal_q;
      o_sync_q     <= sync_q;
      o_bright_q   <= bright_q;
      o_vol_q      <= vol_q;
      o_upd_q      <= upd_q;
      o_mal_q      <= mal_q;
      o_unk_q      <= unk_q;
      o_app_q      <= app_q;
      o_len_q      <= tl_w[4:0];
      char_ram_q   <= hit && !sel_dflt;
      char_const_q <= const_char;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign monitor_state_o  = o_mon_q;
  assign progress_done_o  = o_pdone_q;
  assign progress_max_o   = o_ptotal_q;
  assign sync_seconds_o   = o_sync_q;
  assign brightness_o     = o_bright_q;
  assign volume_o         = o_vol_q;
  assign updated_flag_o   = o_upd_q;
  assign malformed_o      = o_mal_q;
  assign unknown_count_o  = o_unk_q;
  assign applied_count_o  = o_app_q;
  assign text_length_o    = o_len_q;
  // RAM read data holds until the next read, which waits for the slot to free
  assign text_char_o      = char_ram_q ? ram_rdata : char_const_q;

endmodule

`default_nettype wire

FILE: rtl/tpu_checker.sv
// ----------------------------------------------------------------------------
// tpu_checker
// Port-level checks of the telemetry parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] sync_seconds_o,
  input wire logic [7:0]  text_char_o,
  input wire logic [7:0]  monitor_state_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sync_seconds_o) && $stable(text_char_o)
                                   && $stable(monitor_state_o))
    else $error("result changed while stalled");

  // with the result slot free the back end drains, so the queue cannot be full
  a_no_stall_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !in_stall_o)
    else $error("input stalled with free result slot");

  a_no_stall_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |=> !in_stall_o)
    else $error("input stalled while output drains");

endmodule

bind tlv_telemetry_parser_unit tpu_checker u_tpu_checker (.*);

`default_nettype wire
